// ===== rtl/core/ehi_pkg.sv =====
// ----------------------------------------------------------------------------
// ehi_pkg
// shared codes, command and status types of the extendible hash index
// ----------------------------------------------------------------------------
package ehi_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_OVF      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOMORE   = 3'd4;

  typedef enum logic [4:0] {
    C_NONE,
    C_CLR,
    C_LATCH,
    C_DIR_RD,
    C_DIR_GET,
    C_BI_GET,
    C_ENT_RD,
    C_NEXT,
    C_EMIT_RID,
    C_HIT,
    C_ACC,
    C_EMIT,
    C_LAST_RD,
    C_DEL_WR,
    C_STORE,
    C_J0,
    C_DBL_RD,
    C_DBL_WR,
    C_ALLOC,
    C_REDIR_RD,
    C_REDIR_WR,
    C_COPY_RD,
    C_COPY_WR,
    C_BUF_RD,
    C_MOVE_WR,
    C_WB_B,
    C_WB_NB
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       j_eq_n;
    logic       key_eq;
    logic       pair_eq;
    logic       found;
    logic       full;
    logic       ovf;
    logic       out_free;
    logic       clr_last;
    logic       dbl_last;
    logic       redir_last;
    logic       slot_last;
    logic       d_ge_g;
  } stat_t;

endpackage

// ===== rtl/core/ehi_if.sv =====
// ----------------------------------------------------------------------------
// ehi_if
// valid/ready channels of the extendible hash index
// ----------------------------------------------------------------------------
interface ehi_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] key;
  logic [31:0]        rid;
  modport source (output valid, action, key, rid, input ready);
  modport sink (input valid, action, key, rid, output ready);
endinterface

interface ehi_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] rid_out;
  logic        last;
  modport source (output valid, status, rid_out, last, input ready);
  modport sink (input valid, status, rid_out, last, output ready);
endinterface

interface ehi_cfg_if;
  logic valid;
  logic ready;
  logic unique_check;
  modport source (output valid, unique_check, input ready);
  modport sink (input valid, unique_check, output ready);
endinterface

// ===== rtl/core/ehi_ram.sv =====
// ----------------------------------------------------------------------------
// ehi_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ehi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ehi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ehi_ctrl
// sequencer for lookup, delete, insert and bucket split
// ----------------------------------------------------------------------------
module ehi_ctrl import ehi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [22:0] {
    S_CLR    = 23'h1 << 0,
    S_IDLE   = 23'h1 << 1,
    S_DIR    = 23'h1 << 2,
    S_DIRW   = 23'h1 << 3,
    S_BIW    = 23'h1 << 4,
    S_SCAN   = 23'h1 << 5,
    S_CHK    = 23'h1 << 6,
    S_RES    = 23'h1 << 7,
    S_DELRD  = 23'h1 << 8,
    S_DELWR  = 23'h1 << 9,
    S_PLACE  = 23'h1 << 10,
    S_DBL    = 23'h1 << 11,
    S_DBLW   = 23'h1 << 12,
    S_ALLOC  = 23'h1 << 13,
    S_REDIR  = 23'h1 << 14,
    S_REDIRW = 23'h1 << 15,
    S_COPY   = 23'h1 << 16,
    S_COPYW  = 23'h1 << 17,
    S_MOVE   = 23'h1 << 18,
    S_MOVEW  = 23'h1 << 19,
    S_WBB    = 23'h1 << 20,
    S_WBNB   = 23'h1 << 21,
    S_SPARE  = 23'h1 << 22
  } state_t;

  state_t     state, state_next;
  logic       placing, placing_next;
  logic [2:0] res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      placing <= 1'b0;
      res     <= ST_OK;
    end else begin
      state   <= state_next;
      placing <= placing_next;
      res     <= res_next;
    end
  end

  always_comb begin
    state_next   = state;
    placing_next = placing;
    res_next     = res;
    cmd.op       = C_NONE;
    cmd.st       = res;
    in_ready     = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.op = C_CLR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op       = C_LATCH;
          placing_next = 1'b0;
          state_next   = S_DIR;
        end
      end
      S_DIR: begin
        cmd.op     = C_DIR_RD;
        state_next = S_DIRW;
      end
      S_DIRW: begin
        cmd.op     = C_DIR_GET;
        state_next = S_BIW;
      end
      S_BIW: begin
        cmd.op = C_BI_GET;
        if (placing) begin
          state_next = S_PLACE;
        end else if (stat.act != ACT_INSERT && stat.act != ACT_DELETE &&
                     stat.act != ACT_LOOKUP) begin
          res_next   = ST_NOTFOUND;
          state_next = S_RES;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.j_eq_n) begin
          cmd.op     = C_ENT_RD;
          state_next = S_CHK;
        end else if (stat.act == ACT_LOOKUP) begin
          res_next   = ST_NOMORE;
          state_next = S_RES;
        end else if (stat.act == ACT_DELETE) begin
          res_next   = ST_NOTFOUND;
          state_next = S_RES;
        end else if (stat.found) begin
          res_next   = ST_DUP;
          state_next = S_RES;
        end else if (stat.full && stat.ovf) begin
          res_next   = ST_OVF;
          state_next = S_RES;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_CHK: begin
        if (stat.act == ACT_LOOKUP) begin
          if (!stat.key_eq) begin
            cmd.op     = C_NEXT;
            state_next = S_SCAN;
          end else if (stat.out_free) begin
            cmd.op     = C_EMIT_RID;
            state_next = S_SCAN;
          end
        end else if (stat.act == ACT_DELETE) begin
          if (stat.pair_eq) begin
            cmd.op     = C_HIT;
            state_next = S_DELRD;
          end else begin
            cmd.op     = C_NEXT;
            state_next = S_SCAN;
          end
        end else begin
          cmd.op     = C_ACC;
          state_next = S_SCAN;
        end
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.op     = C_EMIT;
          state_next = S_IDLE;
        end
      end
      S_DELRD: begin
        cmd.op     = C_LAST_RD;
        state_next = S_DELWR;
      end
      S_DELWR: begin
        cmd.op     = C_DEL_WR;
        res_next   = ST_OK;
        state_next = S_RES;
      end
      S_PLACE: begin
        if (!stat.full) begin
          cmd.op     = C_STORE;
          res_next   = ST_OK;
          state_next = S_RES;
        end else begin
          cmd.op     = C_J0;
          state_next = stat.d_ge_g ? S_DBL : S_ALLOC;
        end
      end
      S_DBL: begin
        cmd.op     = C_DBL_RD;
        state_next = S_DBLW;
      end
      S_DBLW: begin
        cmd.op     = C_DBL_WR;
        state_next = stat.dbl_last ? S_ALLOC : S_DBL;
      end
      S_ALLOC: begin
        cmd.op     = C_ALLOC;
        state_next = S_REDIR;
      end
      S_REDIR: begin
        cmd.op     = C_REDIR_RD;
        state_next = S_REDIRW;
      end
      S_REDIRW: begin
        cmd.op     = C_REDIR_WR;
        state_next = stat.redir_last ? S_COPY : S_REDIR;
      end
      S_COPY: begin
        cmd.op     = C_COPY_RD;
        state_next = S_COPYW;
      end
      S_COPYW: begin
        cmd.op     = C_COPY_WR;
        state_next = stat.slot_last ? S_MOVE : S_COPY;
      end
      S_MOVE: begin
        cmd.op     = C_BUF_RD;
        state_next = S_MOVEW;
      end
      S_MOVEW: begin
        cmd.op     = C_MOVE_WR;
        state_next = stat.slot_last ? S_WBB : S_MOVE;
      end
      S_WBB: begin
        cmd.op     = C_WB_B;
        state_next = S_WBNB;
      end
      S_WBNB: begin
        cmd.op       = C_WB_NB;
        placing_next = 1'b1;
        state_next   = S_DIR;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ehi_dpath.sv =====
// ----------------------------------------------------------------------------
// ehi_dpath
// directory, bucket info and entry memories with scan and split datapath
// ----------------------------------------------------------------------------
module ehi_dpath import ehi_pkg::*; #(
  parameter int DIR_ENTRIES  = 64,
  parameter int BUCKET_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         action,
  input  logic signed [31:0] key,
  input  logic [31:0]        rid,
  input  logic               cfg_valid,
  input  logic               cfg_unique,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [31:0]        out_rid,
  output logic               out_last
);

  localparam int L   = $clog2(DIR_ENTRIES);
  localparam int DW  = $clog2(L + 1);
  localparam int FW  = $clog2(BUCKET_SLOTS + 1);
  localparam int UW  = $clog2(DIR_ENTRIES + 1);
  localparam int OW  = UW + 2;
  localparam int EAW = $clog2(DIR_ENTRIES * BUCKET_SLOTS);
  localparam int SAW = $clog2(BUCKET_SLOTS);
  localparam int JW  = (L > FW) ? L : FW;
  localparam int BIW = DW + FW;

  function automatic logic [L-1:0] mag_low(input logic [31:0] k);
    logic [L-1:0] lo;
    lo = k[L-1:0];
    mag_low = k[31] ? L'(~lo + 1'b1) : lo;
  endfunction

  logic [1:0]    act;
  logic [31:0]   key_q, rid_q;
  logic [L-1:0]  magk, bkt, nb;
  logic [DW-1:0] d, g, dmin;
  logic [FW-1:0] n, slot, fb, fnb;
  logic [JW-1:0] j;
  logic [UW-1:0] used;
  logic          uniq, found;

  logic             dir_we;
  logic [L-1:0]     dir_waddr, dir_wdata, dir_raddr, dir_rdata;
  logic             bi_we;
  logic [L-1:0]     bi_waddr, bi_raddr;
  logic [BIW-1:0]   bi_wdata, bi_rdata;
  logic             ent_we;
  logic [EAW-1:0]   ent_waddr, ent_raddr;
  logic [63:0]      ent_wdata, ent_rdata;
  logic             buf_we;
  logic [63:0]      buf_rdata;

  logic [L-1:0]   j_l, mask_g, x, magb_sh, j_sh;
  logic [DW-1:0]  cand;
  logic           cand_hit;
  logic [EAW-1:0] base_b, base_nb;
  logic           side;
  logic           out_free;

  ehi_ram #(.WIDTH(L), .DEPTH(DIR_ENTRIES)) u_dir (
    .clk, .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );
  ehi_ram #(.WIDTH(BIW), .DEPTH(DIR_ENTRIES)) u_binfo (
    .clk, .we(bi_we), .waddr(bi_waddr), .wdata(bi_wdata),
    .raddr(bi_raddr), .rdata(bi_rdata)
  );
  ehi_ram #(.WIDTH(64), .DEPTH(DIR_ENTRIES * BUCKET_SLOTS)) u_ent (
    .clk, .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );
  ehi_ram #(.WIDTH(64), .DEPTH(BUCKET_SLOTS)) u_buf (
    .clk, .we(buf_we), .waddr(j[SAW-1:0]), .wdata(ent_rdata),
    .raddr(j[SAW-1:0]), .rdata(buf_rdata)
  );

  assign j_l     = j[L-1:0];
  assign mask_g  = ~({L{1'b1}} << g);
  assign base_b  = EAW'(bkt) * EAW'(BUCKET_SLOTS);
  assign base_nb = EAW'(nb) * EAW'(BUCKET_SLOTS);
  assign magb_sh = mag_low(buf_rdata[63:32]) >> d;
  assign side    = magb_sh[0];
  assign j_sh    = j_l >> d;
  assign x       = mag_low(ent_rdata[63:32]) ^ magk;
  assign out_free = !out_valid || out_ready;

  // first differing magnitude bit at or above the local depth
  always_comb begin
    cand     = DW'(L);
    cand_hit = 1'b0;
    for (int p = 0; p < L; p++) begin
      if (!cand_hit && x[p] && DW'(p) >= d) begin
        cand     = DW'(p);
        cand_hit = 1'b1;
      end
    end
  end

  always_comb begin
    stat.act        = act;
    stat.j_eq_n     = j == JW'(n);
    stat.key_eq     = ent_rdata[63:32] == key_q;
    stat.pair_eq    = (ent_rdata[63:32] == key_q) && (ent_rdata[31:0] == rid_q);
    stat.found      = found;
    stat.full       = n == FW'(BUCKET_SLOTS);
    stat.ovf        = (dmin >= DW'(L)) ||
                      ((OW'(used) + OW'(dmin) + OW'(1)) > (OW'(DIR_ENTRIES) + OW'(d)));
    stat.out_free   = out_free;
    stat.clr_last   = j_l == L'(DIR_ENTRIES - 1);
    stat.dbl_last   = j_l == mask_g;
    stat.redir_last = j_l == mask_g;
    stat.slot_last  = (j + JW'(1)) == JW'(n);
    stat.d_ge_g     = d >= g;
  end

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = j_l;
    dir_wdata = '0;
    dir_raddr = j_l;
    bi_we     = 1'b0;
    bi_waddr  = bkt;
    bi_wdata  = '0;
    bi_raddr  = bkt;
    ent_we    = 1'b0;
    ent_waddr = base_b + EAW'(n);
    ent_wdata = {key_q, rid_q};
    ent_raddr = base_b + EAW'(j[FW-1:0]);
    buf_we    = 1'b0;
    case (cmd.op)
      C_CLR: begin
        dir_we = 1'b1;
        bi_we  = 1'b1;
        bi_waddr = j_l;
      end
      C_DIR_RD: dir_raddr = magk & mask_g;
      C_DIR_GET: bi_raddr = dir_rdata;
      C_LAST_RD: ent_raddr = base_b + EAW'(n - FW'(1));
      C_DEL_WR: begin
        ent_we    = 1'b1;
        ent_waddr = base_b + EAW'(slot);
        ent_wdata = ent_rdata;
        bi_we     = 1'b1;
        bi_wdata  = {d, FW'(n - FW'(1))};
      end
      C_STORE: begin
        ent_we   = 1'b1;
        bi_we    = 1'b1;
        bi_wdata = {d, FW'(n + FW'(1))};
      end
      C_DBL_WR: begin
        dir_we    = 1'b1;
        dir_waddr = j_l + mask_g + L'(1);
        dir_wdata = dir_rdata;
      end
      C_REDIR_WR: begin
        dir_we    = (dir_rdata == bkt) && j_sh[0];
        dir_wdata = nb;
      end
      C_COPY_WR: buf_we = 1'b1;
      C_MOVE_WR: begin
        ent_we    = 1'b1;
        ent_waddr = side ? base_nb + EAW'(fnb) : base_b + EAW'(fb);
        ent_wdata = buf_rdata;
      end
      C_WB_B: begin
        bi_we    = 1'b1;
        bi_wdata = {DW'(d + DW'(1)), fb};
      end
      C_WB_NB: begin
        bi_we    = 1'b1;
        bi_waddr = nb;
        bi_wdata = {DW'(d + DW'(1)), fnb};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j         <= '0;
      g         <= '0;
      used      <= UW'(1);
      uniq      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) uniq <= cfg_unique;
      if (cmd.op == C_EMIT_RID || cmd.op == C_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        C_CLR: j <= stat.clr_last ? '0 : j + JW'(1);
        C_LATCH: begin
          act   <= action;
          key_q <= key;
          rid_q <= rid;
          magk  <= mag_low(key);
        end
        C_DIR_GET: bkt <= dir_rdata;
        C_BI_GET: begin
          d     <= bi_rdata[BIW-1:FW];
          n     <= bi_rdata[FW-1:0];
          j     <= '0;
          found <= 1'b0;
          dmin  <= DW'(L);
        end
        C_NEXT: j <= j + JW'(1);
        C_EMIT_RID: begin
          j          <= j + JW'(1);
          out_status <= ST_OK;
          out_rid    <= ent_rdata[31:0];
          out_last   <= 1'b0;
        end
        C_HIT: slot <= j[FW-1:0];
        C_ACC: begin
          j <= j + JW'(1);
          if (uniq && stat.pair_eq) found <= 1'b1;
          if (cand < dmin) dmin <= cand;
        end
        C_EMIT: begin
          out_status <= cmd.st;
          out_rid    <= '0;
          out_last   <= 1'b1;
        end
        C_J0: j <= '0;
        C_DBL_WR: begin
          if (stat.dbl_last) begin
            j <= '0;
            g <= g + DW'(1);
          end else begin
            j <= j + JW'(1);
          end
        end
        C_ALLOC: begin
          nb   <= used[L-1:0];
          used <= used + UW'(1);
          j    <= '0;
        end
        C_REDIR_WR: j <= stat.redir_last ? '0 : j + JW'(1);
        C_COPY_WR: begin
          if (stat.slot_last) begin
            j   <= '0;
            fb  <= '0;
            fnb <= '0;
          end else begin
            j <= j + JW'(1);
          end
        end
        C_MOVE_WR: begin
          j <= j + JW'(1);
          if (side) fnb <= fnb + FW'(1);
          else fb <= fb + FW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/extendible_hash_index_unit.sv =====
// ----------------------------------------------------------------------------
// extendible_hash_index_unit
// Lookup and delete read the directory and bucket info, then scan the bucket;
// output stalls can hold them. Insert scans the same way. A split of a full
// bucket may double the directory, redirects directory entries, then copies and
// moves its entries, using the registered reads of the directory and entries.
// One transaction is handled at a time.
// Reset: a clearing pass zeroes directory and bucket info.
// ----------------------------------------------------------------------------
module extendible_hash_index_unit import ehi_pkg::*; #(
  parameter int DIR_ENTRIES  = 64,
  parameter int BUCKET_SLOTS = 8
) (
  input logic    clk,
  input logic    rst,
  ehi_req_if.sink  req,
  ehi_rsp_if.source rsp,
  ehi_cfg_if.sink  cfg
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  ehi_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid),
    .in_ready,
    .stat,
    .cmd
  );

  ehi_dpath #(
    .DIR_ENTRIES(DIR_ENTRIES),
    .BUCKET_SLOTS(BUCKET_SLOTS)
  ) u_dpath (
    .clk, .rst,
    .cmd,
    .stat,
    .action(req.action),
    .key(req.key),
    .rid(req.rid),
    .cfg_valid(cfg.valid),
    .cfg_unique(cfg.unique_check),
    .out_ready(rsp.ready),
    .out_valid(rsp.valid),
    .out_status(rsp.status),
    .out_rid(rsp.rid_out),
    .out_last(rsp.last)
  );

endmodule
